/* design/type_length_frame_decoder_core_macros.svh */
// assertion macros shared by the decoder checker
`ifndef TYPE_LENGTH_FRAME_DECODER_CORE_MACROS_SVH
`define TYPE_LENGTH_FRAME_DECODER_CORE_MACROS_SVH

// same-cycle implication, disabled while in reset
`define TLFD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tlfd check failed");

// next-cycle implication, disabled while in reset
`define TLFD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tlfd check failed");

`endif

/* design/tlfd_pkg.sv */
// types, constants and helpers for the type-length frame decoder
package tlfd_pkg;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PAYLOAD = 2'd1,
        PH_HALTED  = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        K_TERM     = 3'd0,
        K_RESIZE   = 3'd1,
        K_OVERSIZE = 3'd2,
        K_BADLEN   = 3'd3,
        K_UNKNOWN  = 3'd4
    } kind_t;

    localparam logic [7:0]  TYPE_TERM   = 8'h00;
    localparam logic [7:0]  TYPE_RESIZE = 8'h01;

    localparam logic [1:0]  CFG_MAX_FRAME_LENGTH = 2'd0;
    localparam logic [1:0]  CFG_MAX_DIMENSION    = 2'd1;

    localparam logic [31:0] MAX_FRAME_LENGTH_RST = 32'd262144;
    localparam logic [15:0] MAX_DIMENSION_RST    = 16'd1000;

    // header bytes after the type byte
    localparam logic [2:0]  HDR_LAST      = 3'd4;
    // payload count saturates above the resize length
    localparam logic [2:0]  RESIZE_LEN    = 3'd4;
    localparam logic [2:0]  PCOUNT_SAT    = 3'd5;

    typedef struct packed {
        phase_t      phase;
        logic [2:0]  header_count;
        logic [7:0]  frame_type;
        logic [31:0] remaining_length;
        logic [23:0] resize_bytes;
        logic [2:0]  payload_count;
    } tlfd_state_t;

    typedef struct packed {
        logic [31:0] max_frame_length;
        logic [15:0] max_dimension;
    } tlfd_cfg_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic        last_of_frame;
        logic [15:0] rows;
        logic [15:0] cols;
    } tlfd_result_t;

    // clamp to 1..max, a max of zero counts as one
    function automatic logic [15:0] bound_dim(input logic [15:0] v, input logic [15:0] max_dim);
        logic [15:0] hi;
        logic [15:0] r;
        hi = (max_dim == 16'd0) ? 16'd1 : max_dim;
        if (v == 16'd0)
            r = 16'd1;
        else if (v > hi)
            r = hi;
        else
            r = v;
        return r;
    endfunction

endpackage

/* design/tlfd_step.sv */
// per-byte next state and result logic of the frame decoder
module tlfd_step
    import tlfd_pkg::*;
(
    input  tlfd_state_t  cur,
    input  tlfd_cfg_t    cfg,
    input  logic [7:0]   stream_byte,
    output tlfd_state_t  nxt,
    output logic         res_valid,
    output tlfd_result_t res
);

    logic [31:0] len_new;
    logic        oversize;
    logic [2:0]  pc_inc;
    logic        rem_one;
    logic        is_term;
    logic        is_resize;

    assign len_new   = {cur.remaining_length[23:0], stream_byte};
    assign oversize  = len_new > cfg.max_frame_length;
    assign pc_inc    = (cur.payload_count >= PCOUNT_SAT) ? PCOUNT_SAT
                                                         : cur.payload_count + 3'd1;
    assign rem_one   = cur.remaining_length == 32'd1;
    assign is_term   = cur.frame_type == TYPE_TERM;
    assign is_resize = cur.frame_type == TYPE_RESIZE;

    // next state
    always_comb
    begin
        nxt = cur;
        case (cur.phase)
            PH_HEADER:
            begin
                if (cur.header_count == 3'd0)
                begin
                    nxt.frame_type       = stream_byte;
                    nxt.remaining_length = 32'd0;
                    nxt.header_count     = 3'd1;
                end
                else
                begin
                    nxt.remaining_length = len_new;
                    if (cur.header_count != HDR_LAST)
                    begin
                        nxt.header_count = cur.header_count + 3'd1;
                    end
                    else
                    begin
                        nxt.header_count  = 3'd0;
                        nxt.resize_bytes  = 24'd0;
                        nxt.payload_count = 3'd0;
                        if (oversize)
                            nxt.phase = PH_HALTED;
                        else if (len_new == 32'd0)
                            nxt.phase = is_term ? PH_HEADER : PH_HALTED;
                        else
                            nxt.phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                nxt.payload_count    = pc_inc;
                nxt.remaining_length = cur.remaining_length - 32'd1;
                if (rem_one)
                begin
                    nxt.header_count = 3'd0;
                    nxt.phase = (is_term || (is_resize && pc_inc == RESIZE_LEN))
                                ? PH_HEADER : PH_HALTED;
                end
                else if (is_resize && pc_inc < RESIZE_LEN)
                begin
                    nxt.resize_bytes = {cur.resize_bytes[15:0], stream_byte};
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
    end

    // result
    always_comb
    begin
        res_valid         = 1'b0;
        res.kind          = K_TERM;
        res.data_byte     = 8'd0;
        res.last_of_frame = 1'b0;
        res.rows          = 16'd0;
        res.cols          = 16'd0;
        case (cur.phase)
            PH_HEADER:
            begin
                if (cur.header_count == HDR_LAST)
                begin
                    if (oversize)
                    begin
                        res_valid = 1'b1;
                        res.kind  = K_OVERSIZE;
                    end
                    else if (len_new == 32'd0 && !is_term)
                    begin
                        res_valid = 1'b1;
                        res.kind  = is_resize ? K_BADLEN : K_UNKNOWN;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                if (is_term)
                begin
                    res_valid         = 1'b1;
                    res.data_byte     = stream_byte;
                    res.last_of_frame = rem_one;
                end
                else if (rem_one)
                begin
                    res_valid = 1'b1;
                    if (!is_resize)
                    begin
                        res.kind = K_UNKNOWN;
                    end
                    else if (pc_inc == RESIZE_LEN)
                    begin
                        res.kind = K_RESIZE;
                        res.rows = bound_dim(cur.resize_bytes[23:8], cfg.max_dimension);
                        res.cols = bound_dim({cur.resize_bytes[7:0], stream_byte},
                                             cfg.max_dimension);
                    end
                    else
                    begin
                        res.kind = K_BADLEN;
                    end
                end
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

endmodule

/* design/type_length_frame_decoder_core.sv */
// top level of the type-length frame decoder
//
//  channel | direction | handshake           | payload
//  --------+-----------+---------------------+-----------------------------------------
//  in      | sink      | in_valid / in_ready | stream_byte
//  out     | source    | out_valid/out_ready | kind, data_byte, last_of_frame, rows, cols
//  cfg     | sink      | cfg_we (no wait)    | cfg_index, cfg_data
//
// one byte per cycle while in_ready is high: each accepted beat goes through the per-byte
// step logic straight into the result register and shows on out_valid in the next cycle
// in_ready is high whenever the result register is empty or being drained this cycle,
// so a result held by a stalled out blocks every input byte, header bytes included
// reset clears the decoder state, the result valid flag and restores both config registers
// after any error result the decoder halts: bytes are still taken but produce nothing
module type_length_frame_decoder_core
    import tlfd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  stream_byte,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  kind,
    output logic [7:0]  data_byte,
    output logic        last_of_frame,
    output logic [15:0] rows,
    output logic [15:0] cols,

    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    tlfd_state_t  state_reg;
    tlfd_state_t  state_next;
    tlfd_cfg_t    cfg_reg;
    tlfd_result_t res_next;
    tlfd_result_t out_reg;
    logic         res_valid;
    logic         out_valid_reg;
    logic         in_accept;

    // result register acts as the skid between the two sides
    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    tlfd_step u_step
    (
        .cur         (state_reg),
        .cfg         (cfg_reg),
        .stream_byte (stream_byte),
        .nxt         (state_next),
        .res_valid   (res_valid),
        .res         (res_next)
    );

    // decoder state advances only on an accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase            <= PH_HEADER;
            state_reg.header_count     <= 3'd0;
            state_reg.frame_type       <= 8'd0;
            state_reg.remaining_length <= 32'd0;
            state_reg.resize_bytes     <= 24'd0;
            state_reg.payload_count    <= 3'd0;
        end
        else if (in_accept)
        begin
            state_reg <= state_next;
        end
    end

    // config writes take effect on the next beat, unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_frame_length <= MAX_FRAME_LENGTH_RST;
            cfg_reg.max_dimension    <= MAX_DIMENSION_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAX_FRAME_LENGTH: cfg_reg.max_frame_length <= cfg_data;
                CFG_MAX_DIMENSION:    cfg_reg.max_dimension    <= cfg_data[15:0];
                default:              cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    // result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_accept && res_valid)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // result payload, loaded only with a new result beat
    always_ff @(posedge clk)
    begin
        if (in_accept && res_valid)
            out_reg <= res_next;
    end

    assign out_valid     = out_valid_reg;
    assign kind          = out_reg.kind;
    assign data_byte     = out_reg.data_byte;
    assign last_of_frame = out_reg.last_of_frame;
    assign rows          = out_reg.rows;
    assign cols          = out_reg.cols;

endmodule

/* design/tlfd_checker.sv */
// port-level checker for the frame decoder and its bind
`include "type_length_frame_decoder_core_macros.svh"

module tlfd_checker
    import tlfd_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic [7:0]  stream_byte,
    input logic        out_valid,
    input logic        out_ready,
    input logic [2:0]  kind,
    input logic [7:0]  data_byte,
    input logic        last_of_frame,
    input logic [15:0] rows,
    input logic [15:0] cols,
    input logic        cfg_we,
    input logic [1:0]  cfg_index,
    input logic [31:0] cfg_data
);

    // stalled result beat holds
    `TLFD_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(kind) && $stable(data_byte) && $stable(last_of_frame) && $stable(rows) && $stable(cols))

    // an empty result register never blocks input
    `TLFD_ASSERT_NOW(a_ready_when_empty, clk, rst_n, !out_valid, in_ready)

    // resize beats carry clamped sizes and no terminal fields
    `TLFD_ASSERT_NOW(a_resize_shape, clk, rst_n, out_valid && kind == K_RESIZE, rows != 16'd0 && cols != 16'd0 && data_byte == 8'd0 && !last_of_frame)

    // once an error beat is taken nothing else comes out
    `TLFD_ASSERT_NEXT(a_halt_after_error, clk, rst_n, out_valid && out_ready && (kind == K_OVERSIZE || kind == K_BADLEN || kind == K_UNKNOWN), !out_valid)

endmodule

bind type_length_frame_decoder_core tlfd_checker u_tlfd_checker (.*);

/* bench/type_length_frame_decoder_core_test.sv */
// self-checking testbench for the type-length frame decoder core
module type_length_frame_decoder_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tlfd_pkg::*;

    // five header bytes: type then four length bytes, msb first
    localparam int HEADER_BYTES  = 5;
    // settle time after the last owed result, before touching registers
    localparam int SETTLE_CYCLES = 4;
    // cycles with no beat on either channel before the run is declared hung
    localparam int STALL_LIMIT   = 2000;
    localparam int REPORT_LIMIT  = 10;
    // indexes with no register behind them, writes there must be dropped
    localparam logic [1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [1:0] CFG_SPARE_HI = 2'd3;

    // receiver behavior, each held for a random stretch of cycles
    typedef enum int {
        DRAIN_FREE,
        DRAIN_COIN,
        DRAIN_PATTERN,
        DRAIN_SLOW
    } drain_style_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  stream_byte = 8'h00;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic        last_of_frame;
    logic [15:0] rows;
    logic [15:0] cols;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = 2'd0;
    logic [31:0] cfg_data = 32'd0;

    type_length_frame_decoder_core DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .stream_byte  (stream_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .data_byte    (data_byte),
        .last_of_frame(last_of_frame),
        .rows         (rows),
        .cols         (cols),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 2 ns clock
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // decoder mirror: register copies and per-byte state
    // ---------------------------------------------------------------
    logic [31:0]  cfg_max_len = MAX_FRAME_LENGTH_RST;
    logic [15:0]  cfg_max_dim = MAX_DIMENSION_RST;

    phase_t       dec_phase = PH_HEADER;
    int unsigned  dec_hdr_count = 0;
    logic [7:0]   dec_type = 8'h00;
    logic [31:0]  dec_remaining = 32'd0;
    logic [23:0]  dec_rsz = 24'd0;
    int unsigned  dec_pcount = 0;

    // results the decoder owes us, oldest first
    tlfd_result_t awaited_results[$];

    int unsigned  mismatch_count = 0;
    int unsigned  bytes_sent = 0;
    int unsigned  burst_left = 0;
    bit           gaps_enabled = 1'b1;

    // clamp into 1..limit, a zero limit acts as one
    function automatic logic [15:0] clamp_dimension(input logic [15:0] v);
        logic [15:0] ceiling;
        ceiling = (cfg_max_dim == 16'd0) ? 16'd1 : cfg_max_dim;
        if (v == 16'd0)
            return 16'd1;
        return (v > ceiling) ? ceiling : v;
    endfunction

    // end of frame: nothing for terminal, a resize or an error otherwise
    task automatic close_frame(input logic [7:0] final_byte, inout tlfd_result_t r,
                               inout bit produce);
        dec_phase = PH_HEADER;
        dec_hdr_count = 0;
        if (dec_type == TYPE_TERM)
            return;
        produce = 1'b1;
        if (dec_type == TYPE_RESIZE)
        begin
            if (dec_pcount != RESIZE_LEN)
            begin
                r.kind = K_BADLEN;
                dec_phase = PH_HALTED;
            end
            else
            begin
                r.kind = K_RESIZE;
                r.rows = clamp_dimension(dec_rsz[23:8]);
                r.cols = clamp_dimension({dec_rsz[7:0], final_byte});
            end
        end
        else
        begin
            r.kind = K_UNKNOWN;
            dec_phase = PH_HALTED;
        end
    endtask

    // one accepted byte through the mirror, queue whatever it yields
    task automatic advance_decoder(input logic [7:0] b);
        tlfd_result_t r;
        bit           produce;
        r = '0;
        produce = 1'b0;
        case (dec_phase)
            PH_HEADER:
            begin
                if (dec_hdr_count == 0)
                begin
                    dec_type = b;
                    dec_remaining = 32'd0;
                    dec_hdr_count = 1;
                end
                else
                begin
                    dec_remaining = {dec_remaining[23:0], b};
                    dec_hdr_count++;
                    if (dec_hdr_count == HEADER_BYTES)
                    begin
                        dec_hdr_count = 0;
                        dec_rsz = 24'd0;
                        dec_pcount = 0;
                        // length check wins over any type check
                        if (dec_remaining > cfg_max_len)
                        begin
                            r.kind = K_OVERSIZE;
                            produce = 1'b1;
                            dec_phase = PH_HALTED;
                        end
                        else if (dec_remaining == 32'd0)
                            close_frame(8'h00, r, produce);
                        else
                            dec_phase = PH_PAYLOAD;
                    end
                end
            end
            PH_PAYLOAD:
            begin
                dec_pcount++;
                dec_remaining--;
                if (dec_type == TYPE_TERM)
                begin
                    r.kind = K_TERM;
                    r.data_byte = b;
                    r.last_of_frame = (dec_remaining == 32'd0);
                    produce = 1'b1;
                    if (r.last_of_frame)
                    begin
                        dec_phase = PH_HEADER;
                        dec_hdr_count = 0;
                    end
                end
                else if (dec_remaining == 32'd0)
                    close_frame(b, r, produce);
                else if (dec_type == TYPE_RESIZE && dec_pcount < RESIZE_LEN)
                    dec_rsz = {dec_rsz[15:0], b};
            end
            // halted, and the unused phase code: bytes vanish
            default: ;
        endcase
        if (produce)
            awaited_results.push_back(r);
    endtask

    // ---------------------------------------------------------------
    // result checker: every out beat against the oldest expectation
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        tlfd_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= REPORT_LIMIT)
                    $display("result beat with nothing expected:",
                             " kind %0d data %02h last %0b rows %0d cols %0d",
                             kind, data_byte, last_of_frame, rows, cols);
            end
            else
            begin
                want = awaited_results.pop_front();
                if (kind !== want.kind || data_byte !== want.data_byte ||
                    last_of_frame !== want.last_of_frame || rows !== want.rows ||
                    cols !== want.cols)
                begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_LIMIT)
                        $display("result mismatch: want kind %0d data %02h last %0b",
                                 want.kind, want.data_byte, want.last_of_frame,
                                 " rows %0d cols %0d,", want.rows, want.cols,
                                 " got kind %0d data %02h last %0b",
                                 kind, data_byte, last_of_frame,
                                 " rows %0d cols %0d", rows, cols);
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // receiver: out_ready changes at the falling edge, style per stretch
    // ---------------------------------------------------------------
    int unsigned  drain_left = 0;
    drain_style_t drain_style = DRAIN_FREE;
    logic [7:0]   drain_mask = 8'hFF;

    always @(negedge clk)
    begin
        if (drain_left == 0)
        begin
            drain_left = $urandom_range(16, 96);
            drain_style = drain_style_t'($urandom_range(0, 3));
            // never an all-zero mask, or the pattern would stall for good
            drain_mask = 8'($urandom) | 8'h01;
        end
        drain_left--;
        drain_mask = {drain_mask[6:0], drain_mask[7]};
        case (drain_style)
            DRAIN_FREE:    out_ready <= 1'b1;
            DRAIN_COIN:    out_ready <= 1'($urandom_range(0, 1));
            DRAIN_PATTERN: out_ready <= drain_mask[0];
            default:       out_ready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // ---------------------------------------------------------------
    // hang detector: any beat on either channel resets the count
    // ---------------------------------------------------------------
    initial
    begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("type_length_frame_decoder_core_test: errors");
        $finish;
    end

    // ---------------------------------------------------------------
    // sender side
    // ---------------------------------------------------------------

    // one input beat; bursts of random length with random gaps between
    task automatic send_byte(input logic [7:0] value);
        int unsigned gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            if (gaps_enabled && $urandom_range(0, 3) != 0)
                gap = $urandom_range(1, 6);
        end
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        stream_byte <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        burst_left--;
        bytes_sent++;
        advance_decoder(value);
    endtask

    // drop valid once the last beat went through
    task automatic release_input();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
    endtask

    // every owed result delivered, then a settle wait for header-only bytes in flight
    task automatic wait_drained();
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // register writes only with the decoder quiet; spare index written too
    task automatic apply_settings(input logic [31:0] frame_limit, input logic [15:0] dim_limit);
        release_input();
        wait_drained();
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_MAX_FRAME_LENGTH;
        cfg_data <= frame_limit;
        @(negedge clk);
        // upper bits are junk, only the low half belongs to the register
        cfg_index <= CFG_MAX_DIMENSION;
        cfg_data <= {16'($urandom), dim_limit};
        @(negedge clk);
        cfg_index <= $urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO;
        cfg_data <= $urandom;
        @(negedge clk);
        cfg_we <= 1'b0;
        cfg_max_len = frame_limit;
        cfg_max_dim = dim_limit;
    endtask

    task automatic send_header(input logic [7:0] frame_type, input logic [31:0] len);
        send_byte(frame_type);
        send_byte(len[31:24]);
        send_byte(len[23:16]);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
    endtask

    task automatic send_terminal(input int unsigned len);
        send_header(TYPE_TERM, len);
        repeat (len) send_byte(8'($urandom));
    endtask

    task automatic send_resize(input logic [15:0] r, input logic [15:0] c);
        send_header(TYPE_RESIZE, 32'd4);
        send_byte(r[15:8]);
        send_byte(r[7:0]);
        send_byte(c[15:8]);
        send_byte(c[7:0]);
    endtask

    // dimension values near the clamp edges, plus plain random ones
    function automatic logic [15:0] pick_dimension();
        logic [15:0] ceiling;
        ceiling = (cfg_max_dim == 16'd0) ? 16'd1 : cfg_max_dim;
        case ($urandom_range(0, 7))
            0:       return 16'd0;
            1:       return 16'd1;
            2:       return ceiling - 16'd1;
            3:       return ceiling;
            4:       return ceiling + 16'd1;
            5:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    // a well-formed frame that fits the current length limit
    task automatic send_random_frame();
        int unsigned top;
        int unsigned len;
        if ($urandom_range(0, 99) < 40 && cfg_max_len >= 32'd4)
            send_resize(pick_dimension(), pick_dimension());
        else
        begin
            top = (cfg_max_len < 32'd300) ? cfg_max_len : 300;
            // mostly short payloads, now and then a long one
            if ($urandom_range(0, 19) == 0)
                len = $urandom_range(0, top);
            else
                len = $urandom_range(0, (top < 12) ? top : 12);
            send_terminal(len);
        end
    endtask

    // ---------------------------------------------------------------
    // tests
    // ---------------------------------------------------------------

    // registers untouched: reset limits must already be in force
    task automatic test_default_settings();
        send_header(TYPE_TERM, 32'd1);
        send_byte(8'h00);
        send_header(TYPE_TERM, 32'd2);
        send_byte(8'hFF);
        send_byte(8'h5A);
        // empty terminal frame: no beat at all
        send_header(TYPE_TERM, 32'd0);
        send_resize(16'd0, 16'hFFFF);
        send_resize(16'd1000, 16'd1001);
        send_resize(16'h0102, 16'h0304);
    endtask

    // clamp bound at zero, one and full scale
    task automatic test_dimension_clamp();
        apply_settings(MAX_FRAME_LENGTH_RST, 16'd0);
        send_resize(16'd0, 16'd2);
        apply_settings(MAX_FRAME_LENGTH_RST, 16'hFFFF);
        send_resize(16'hFFFF, 16'd0);
        apply_settings(MAX_FRAME_LENGTH_RST, 16'd1);
        send_resize(16'd2, 16'd1);
    endtask

    // length limit at zero, exactly the resize length, and all ones
    task automatic test_length_limit();
        apply_settings(32'd0, 16'd500);
        send_header(TYPE_TERM, 32'd0);
        send_header(TYPE_TERM, 32'd0);
        apply_settings(32'd4, 16'd500);
        send_terminal(4);
        send_resize(16'd499, 16'd501);
        apply_settings(32'hFFFF_FFFF, 16'd500);
        send_terminal(3);
    endtask

    // bulk traffic over several limit pairs, with quiet and busy stretches
    task automatic test_random_frames();
        logic [31:0] frame_limit;
        logic [15:0] dim_limit;
        int unsigned stop_at;
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0:
                begin
                    frame_limit = 32'hFFFF_FFFF;
                    dim_limit = 16'hFFFF;
                end
                1:
                begin
                    frame_limit = 32'd4;
                    dim_limit = 16'd0;
                end
                2:
                begin
                    frame_limit = $urandom_range(5, 40);
                    dim_limit = 16'($urandom_range(1, 65535));
                end
                3:
                begin
                    frame_limit = 32'd0;
                    dim_limit = 16'($urandom_range(1, 65535));
                end
                4:
                begin
                    frame_limit = MAX_FRAME_LENGTH_RST;
                    dim_limit = MAX_DIMENSION_RST;
                end
                default:
                begin
                    frame_limit = $urandom_range(300, 5000);
                    dim_limit = 16'($urandom_range(1, 300));
                end
            endcase
            apply_settings(frame_limit, dim_limit);
            // one stretch runs flat out on the input side
            gaps_enabled = (p != 2);
            // a zero limit only allows empty frames, keep that stretch short
            stop_at = bytes_sent + ((frame_limit == 32'd0) ? 30 : 140);
            while (bytes_sent < stop_at)
            begin
                send_random_frame();
                // sender holds off until the decoder has nothing left to give
                if ($urandom_range(0, 39) == 0)
                begin
                    release_input();
                    wait_drained();
                end
            end
        end
        gaps_enabled = 1'b1;
    endtask

    // one fatal error per run, picked at random, then bytes that must vanish
    task automatic test_halt_on_error();
        int unsigned len;
        apply_settings($urandom_range(16, 1000), 16'($urandom_range(1, 65535)));
        send_random_frame();
        case ($urandom_range(0, 4))
            0:
            begin
                // too long: any type byte, length check comes first
                len = cfg_max_len + 32'd1 + ($urandom % (32'hFFFF_FFFF - cfg_max_len));
                send_header(8'($urandom), len);
            end
            1:
                send_header(TYPE_RESIZE, 32'd0);
            2:
            begin
                // resize with a wrong length: payload eaten, error on its last byte
                len = $urandom_range(1, 7);
                if (len >= RESIZE_LEN)
                    len++;
                send_header(TYPE_RESIZE, len);
                repeat (len) send_byte(8'($urandom));
            end
            3:
                send_header(8'($urandom_range(2, 255)), 32'd0);
            default:
            begin
                // unknown type with a payload: silent until its last byte
                len = $urandom_range(1, 10);
                send_header(8'($urandom_range(2, 255)), len);
                repeat (len) send_byte(8'($urandom));
            end
        endcase
        // halted: nothing from here on may come out
        repeat (24) send_byte(8'($urandom));
        send_resize(16'd7, 16'd9);
        send_terminal(3);
    endtask

    // ---------------------------------------------------------------
    // sequence
    // ---------------------------------------------------------------
    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_default_settings();
        test_dimension_clamp();
        test_length_limit();
        test_random_frames();
        test_halt_on_error();

        release_input();
        wait_drained();

        if (mismatch_count == 0 && awaited_results.size() == 0)
            $display("type_length_frame_decoder_core_test: clean");
        else
            $display("type_length_frame_decoder_core_test: errors");
        $finish;
    end

endmodule

/* files.f */
+incdir+design
design/tlfd_pkg.sv
design/tlfd_step.sv
design/type_length_frame_decoder_core.sv
design/tlfd_checker.sv
bench/type_length_frame_decoder_core_test.sv
